FILE: rtl/npfc_pkg.sv
`timescale 1ns / 1ps

package npfc_pkg;

    localparam int C_COORD_BITS    = 12;
    localparam int C_CORNER_BITS   = 16;
    localparam int C_NCORNER       = 4;
    localparam int C_NREG          = 8;
    localparam int C_APB_ADDR_BITS = 5;
    localparam int C_APB_DATA_BITS = 32;

    typedef enum logic [2:0] {
        REG_TL_X = 3'd0,
        REG_TL_Y = 3'd1,
        REG_TR_X = 3'd2,
        REG_TR_Y = 3'd3,
        REG_BR_X = 3'd4,
        REG_BR_Y = 3'd5,
        REG_BL_X = 3'd6,
        REG_BL_Y = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        CRN_TL = 2'd0,
        CRN_TR = 2'd1,
        CRN_BR = 2'd2,
        CRN_BL = 2'd3
    } t_corner_idx;

    typedef logic [C_COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   last_point;
    } t_in_beat;

    typedef struct packed {
        t_coord top_left_x;
        t_coord top_left_y;
        t_coord top_right_x;
        t_coord top_right_y;
        t_coord bottom_right_x;
        t_coord bottom_right_y;
        t_coord bottom_left_x;
        t_coord bottom_left_y;
    } t_out_beat;

    typedef struct packed {
        logic [C_CORNER_BITS-1:0] x;
        logic [C_CORNER_BITS-1:0] y;
    } t_corner;

    typedef t_corner [C_NCORNER-1:0] t_corner_set;

    // Control and payload of one beat passed from the distance pipeline to the tracker.
    typedef struct packed {
        logic     vld;
        t_in_beat beat;
    } t_stage_info;

    // Width of a signed coordinate difference that holds any point minus any corner.
    function automatic int f_diff_width(input int frac_bits);
        int shw;
        int sw;
        begin
            shw = C_COORD_BITS + frac_bits;
            sw  = (shw + 1 > C_CORNER_BITS) ? shw + 1 : C_CORNER_BITS;
            f_diff_width = sw + 1;
        end
    endfunction

endpackage

FILE: rtl/npfc_cfg.sv
`timescale 1ns / 1ps

module npfc_cfg import npfc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [C_APB_ADDR_BITS-1:0] paddr,
    input  logic [C_APB_DATA_BITS-1:0] pwdata,
    output logic [C_APB_DATA_BITS-1:0] prdata,
    output logic                       pready,
    output t_corner_set                o_corners
);

    logic [C_CORNER_BITS-1:0] r_reg [C_NREG];
    t_reg_idx                 w_idx;
    logic                     w_wr;

    assign w_idx  = t_reg_idx'(paddr[C_APB_ADDR_BITS-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < C_NREG; i++) begin
                r_reg[i] <= '0;
            end
        end else if (w_wr) begin
            r_reg[w_idx] <= pwdata[C_CORNER_BITS-1:0];
        end
    end

    // Reads return the register sign-extended to the bus width.
    assign prdata = {{(C_APB_DATA_BITS-C_CORNER_BITS){r_reg[w_idx][C_CORNER_BITS-1]}},
                     r_reg[w_idx]};

    always_comb begin
        o_corners[CRN_TL].x = r_reg[REG_TL_X];
        o_corners[CRN_TL].y = r_reg[REG_TL_Y];
        o_corners[CRN_TR].x = r_reg[REG_TR_X];
        o_corners[CRN_TR].y = r_reg[REG_TR_Y];
        o_corners[CRN_BR].x = r_reg[REG_BR_X];
        o_corners[CRN_BR].y = r_reg[REG_BR_Y];
        o_corners[CRN_BL].x = r_reg[REG_BL_X];
        o_corners[CRN_BL].y = r_reg[REG_BL_Y];
    end

endmodule

FILE: rtl/npfc_dist.sv
`timescale 1ns / 1ps

module npfc_dist import npfc_pkg::*; #(
    parameter int FRAC_BITS = 4,
    parameter int DSTW      = 2 * f_diff_width(FRAC_BITS)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  t_in_beat                        i_in_beat,
    output logic                            o_in_stall,
    input  t_corner_set                     i_corners,
    input  logic                            i_go,
    output t_stage_info                     o_stage,
    output logic [C_NCORNER-1:0][DSTW-1:0]  o_dist
);

    localparam int DW  = f_diff_width(FRAC_BITS);
    localparam int SQW = 2 * DW;

    logic signed [DW-1:0]  w_px;
    logic signed [DW-1:0]  w_py;
    logic signed [DW-1:0]  w_dx  [C_NCORNER];
    logic signed [DW-1:0]  w_dy  [C_NCORNER];
    logic        [SQW-1:0] w_sqx [C_NCORNER];
    logic        [SQW-1:0] w_sqy [C_NCORNER];
    logic                  w_go1;
    logic                  w_accept;

    logic                  r1_vld;
    t_in_beat              r1_beat;
    logic        [SQW-1:0] r1_sqx [C_NCORNER];
    logic        [SQW-1:0] r1_sqy [C_NCORNER];
    logic                  r2_vld;
    t_in_beat              r2_beat;
    logic        [DSTW-1:0] r2_dist [C_NCORNER];

    assign w_go1      = !r1_vld || i_go;
    assign w_accept   = i_in_valid && w_go1;
    assign o_in_stall = !w_go1;

    // Whole pixels become Q.FRAC_BITS by a left shift; exact at this width.
    assign w_px = $signed(DW'(i_in_beat.point_x) << FRAC_BITS);
    assign w_py = $signed(DW'(i_in_beat.point_y) << FRAC_BITS);

    always_comb begin
        for (int k = 0; k < C_NCORNER; k++) begin
            w_dx[k]  = w_px - DW'($signed(i_corners[k].x));
            w_dy[k]  = w_py - DW'($signed(i_corners[k].y));
            w_sqx[k] = w_dx[k] * w_dx[k];
            w_sqy[k] = w_dy[k] * w_dy[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (w_go1) begin
                r1_vld <= w_accept;
            end
            if (i_go) begin
                r2_vld <= r1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_beat <= i_in_beat;
            for (int k = 0; k < C_NCORNER; k++) begin
                r1_sqx[k] <= w_sqx[k];
                r1_sqy[k] <= w_sqy[k];
            end
        end
        if (i_go && r1_vld) begin
            r2_beat <= r1_beat;
            for (int k = 0; k < C_NCORNER; k++) begin
                r2_dist[k] <= DSTW'(r1_sqx[k]) + DSTW'(r1_sqy[k]);
            end
        end
    end

    assign o_stage.vld  = r2_vld;
    assign o_stage.beat = r2_beat;

    always_comb begin
        for (int k = 0; k < C_NCORNER; k++) begin
            o_dist[k] = r2_dist[k];
        end
    end

endmodule

FILE: rtl/npfc_best.sv
`timescale 1ns / 1ps

module npfc_best import npfc_pkg::*; #(
    parameter int DSTW = 36
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_stage_info                     i_stage,
    input  logic [C_NCORNER-1:0][DSTW-1:0]  i_dist,
    output logic                            o_go,
    output logic                            o_out_valid,
    output t_out_beat                       o_out_beat,
    input  logic                            i_out_stall
);

    logic              r_have;
    logic              r_out_vld;
    t_out_beat         r_out_beat;
    logic [DSTW-1:0]   r_best_d [C_NCORNER];
    t_point            r_best_p [C_NCORNER];

    logic [DSTW-1:0]   n_best_d [C_NCORNER];
    t_point            n_best_p [C_NCORNER];
    t_point            w_point;
    logic              w_out_free;
    logic              w_upd;
    logic              w_last;

    assign w_point.x  = i_stage.beat.point_x;
    assign w_point.y  = i_stage.beat.point_y;
    assign w_last     = i_stage.beat.last_point;
    assign w_out_free = !r_out_vld || !i_out_stall;
    // Only a closing point needs room in the result register.
    assign o_go       = !i_stage.vld || !w_last || w_out_free;
    assign w_upd      = i_stage.vld && o_go;

    always_comb begin
        for (int k = 0; k < C_NCORNER; k++) begin
            if (!r_have || (i_dist[k] < r_best_d[k])) begin
                n_best_d[k] = i_dist[k];
                n_best_p[k] = w_point;
            end else begin
                n_best_d[k] = r_best_d[k];
                n_best_p[k] = r_best_p[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_upd) begin
                r_have <= !w_last;
            end
            if (w_upd && w_last) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            for (int k = 0; k < C_NCORNER; k++) begin
                r_best_d[k] <= n_best_d[k];
                r_best_p[k] <= n_best_p[k];
            end
        end
        if (w_upd && w_last) begin
            r_out_beat.top_left_x     <= n_best_p[CRN_TL].x;
            r_out_beat.top_left_y     <= n_best_p[CRN_TL].y;
            r_out_beat.top_right_x    <= n_best_p[CRN_TR].x;
            r_out_beat.top_right_y    <= n_best_p[CRN_TR].y;
            r_out_beat.bottom_right_x <= n_best_p[CRN_BR].x;
            r_out_beat.bottom_right_y <= n_best_p[CRN_BR].y;
            r_out_beat.bottom_left_x  <= n_best_p[CRN_BL].x;
            r_out_beat.bottom_left_y  <= n_best_p[CRN_BL].y;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd && w_last) |=> !r_have)
        else $error("candidate flag not cleared after the closing point");

    a_mid_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd && !w_last) |=> r_have)
        else $error("candidate flag not set after a point");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !(i_stage.vld && w_last && o_go))
        else $error("closing point taken while the result beat is stalled");

    a_dist_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd && !w_last && r_have) |=> (r_best_d[CRN_TL] <= $past(r_best_d[CRN_TL])))
        else $error("kept distance grew within a list");

endmodule

FILE: rtl/nearest_point_to_four_corners_top.sv
`timescale 1ns / 1ps

// Finds, for each of four reference corners (top-left, top-right, bottom-right,
// bottom-left), the contour point of a list that lies nearest to it. Corners are
// written over the APB port as signed Q12.4 pixels at byte addresses 0 to 28, in
// the order x then y for top-left, top-right, bottom-right and bottom-left; write
// them only while the block is idle. Points arrive as whole-pixel beats at one per
// clock cycle and each is compared by exact squared distance, so no rounding ever
// affects the choice; a point replaces the kept one only when it is strictly
// nearer, so on a tie the earlier point stays. The beat that carries last_point
// closes the list: it takes part in the search itself, and once it has passed the
// square and sum registers the four chosen points appear as one result beat, after
// which the next list starts afresh. The squares are registered when the beat is
// accepted, then the sums, and after them the result beat, together with the
// compare-and-keep registers of the tracker, whose feedback lets a new point enter
// every cycle. Input is stalled only when a closing point reaches the tracker
// while the previous result beat is still held.
module nearest_point_to_four_corners_top import npfc_pkg::*; #(
    parameter int FRAC_BITS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // point beats
    input  logic                       i_in_valid,
    input  t_in_beat                   i_in_beat,
    output logic                       o_in_stall,
    // result beats
    output logic                       o_out_valid,
    output t_out_beat                  o_out_beat,
    input  logic                       i_out_stall,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [C_APB_ADDR_BITS-1:0] paddr,
    input  logic [C_APB_DATA_BITS-1:0] pwdata,
    output logic [C_APB_DATA_BITS-1:0] prdata,
    output logic                       pready
);

    // Squared distance width: twice the width of a signed coordinate difference.
    localparam int DSTW = 2 * f_diff_width(FRAC_BITS);

    t_corner_set                    w_corners;
    t_stage_info                    w_stage;
    logic [C_NCORNER-1:0][DSTW-1:0] w_dist;
    logic                           w_go;

    // Corner registers.
    npfc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_corners (w_corners)
    );

    // Two-stage pipeline: squares of the differences, then their sums.
    npfc_dist #(
        .FRAC_BITS (FRAC_BITS),
        .DSTW      (DSTW)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .o_in_stall (o_in_stall),
        .i_corners  (w_corners),
        .i_go       (w_go),
        .o_stage    (w_stage),
        .o_dist     (w_dist)
    );

    // Keeps the nearest point per corner and registers the result beat.
    npfc_best #(
        .DSTW (DSTW)
    ) u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_stage),
        .i_dist      (w_dist),
        .o_go        (w_go),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

endmodule
